// File: hw/rtl/som_bmu_pkg.sv
`default_nettype none

package som_bmu_pkg;

	// default geometry and element width
	localparam int GRID_SIDE_DEF  = 16;
	localparam int PATCH_SIDE_DEF = 3;
	localparam int VALUE_BITS_DEF = 16;

	// output distance width and its saturation value
	localparam int          DIST_W   = 36;
	localparam logic [35:0] DIST_MAX = {DIST_W{1'b1}};

	// request function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// one request item
	typedef struct packed {
		logic               func;
		logic [7:0]         entry;
		logic [3:0]         element;
		logic signed [15:0] value;
		logic               last;
	} req_t;

	// one result item
	typedef struct packed {
		logic [3:0]        best_row;
		logic [3:0]        best_col;
		logic [DIST_W-1:0] min_distance;
	} rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/som_best_matching_unit_search_top.sv
`default_nettype none

// Best-matching-unit search over a GRID_SIDE x GRID_SIDE codebook of
// PATCH_SIDE x PATCH_SIDE signed patches held in one single-port-read memory.
// A codebook write item or a query element without last only updates storage.
// A query element with last starts a walk of the whole codebook: one memory
// word and one multiply-accumulate per cycle through the read, difference,
// square and entry-sum registers; the codebook read port sets that rate.
// rsp_valid rises when the done state loads the output register, and the next
// request can be taken as that result appears. No request is taken during the
// walk or while a finished result cannot be placed in the output register.
// The result is the row and column of the closest entry (first in row-major
// order on a tie) and its squared Euclidean distance, saturated to 36 bits.
// Codebook and query words are undefined until written; there is no
// clearing pass after reset.
module som_best_matching_unit_search_top #(
	parameter int GRID_SIDE  = som_bmu_pkg::GRID_SIDE_DEF,
	parameter int PATCH_SIDE = som_bmu_pkg::PATCH_SIDE_DEF,
	parameter int VALUE_BITS = som_bmu_pkg::VALUE_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  som_bmu_pkg::req_t   req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output som_bmu_pkg::rsp_t   rsp
);

	localparam int NUM_ENTRIES = GRID_SIDE * GRID_SIDE;
	localparam int PATCH_LEN   = PATCH_SIDE * PATCH_SIDE;
	localparam int TOTAL       = NUM_ENTRIES * PATCH_LEN;
	localparam int ADDR_W      = $clog2(TOTAL);
	localparam int K_W         = $clog2(PATCH_LEN);
	localparam int RC_W        = $clog2(GRID_SIDE);
	localparam int VB          = VALUE_BITS;
	localparam int SQ_W        = 2 * VB;
	localparam int SUM_W       = SQ_W + $clog2(PATCH_LEN) + 1;
	localparam int CMP_W       = (SUM_W > som_bmu_pkg::DIST_W) ? SUM_W : som_bmu_pkg::DIST_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	// request acceptance and decode
	logic req_acc, cb_we, qb_we, start;
	logic [ADDR_W-1:0] wr_addr;
	logic [VB-1:0]     wr_val;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cb_we     = req_acc && (req.func == som_bmu_pkg::FUNC_WRITE)
		&& (32'(req.entry) < NUM_ENTRIES) && (32'(req.element) < PATCH_LEN);
	assign qb_we     = req_acc && (req.func == som_bmu_pkg::FUNC_QUERY)
		&& (32'(req.element) < PATCH_LEN);
	assign start     = req_acc && (req.func == som_bmu_pkg::FUNC_QUERY) && req.last;
	assign wr_addr   = ADDR_W'(ADDR_W'(req.entry) * ADDR_W'(PATCH_LEN)) + ADDR_W'(req.element);
	// low VB bits carry the signed element; wider words zero-extend the field
	assign wr_val    = VB'($unsigned(req.value));

	// walk counters
	logic [ADDR_W-1:0] addr_q;
	logic [K_W-1:0]    k_q;
	logic [RC_W-1:0]   row_q, col_q;
	logic              k_last, col_last, addr_last;

	assign k_last    = (k_q == K_W'(PATCH_LEN - 1));
	assign col_last  = (col_q == RC_W'(GRID_SIDE - 1));
	assign addr_last = (addr_q == ADDR_W'(TOTAL - 1));

	// codebook memory; writes happen only while idle, so no walk read overlaps a write
	logic [VB-1:0] cb_mem [TOTAL];
	logic signed [VB-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (cb_we) begin
			cb_mem[wr_addr] <= wr_val;
		end
		rd_s1 <= cb_mem[addr_q];
	end

	// query patch buffer
	logic [VB-1:0] qbuf_q [PATCH_LEN];

	always_ff @(posedge clk) begin
		if (qb_we) begin
			qbuf_q[K_W'(req.element)] <= wr_val;
		end
	end

	// pipeline: s1 read data, s2 difference, s3 square, s4 entry sum
	logic                 v_s1, v_s2, v_s3, sv_s4;
	logic                 lk_s1, lk_s2, lk_s3;
	logic [RC_W-1:0]      row_s1, row_s2, row_s3, row_s4;
	logic [RC_W-1:0]      col_s1, col_s2, col_s3, col_s4;
	logic signed [VB-1:0] q_s1;
	logic [VB:0]          d_s2;
	logic signed [SQ_W+1:0] prod;
	logic [SQ_W-1:0]      sq_s3;
	logic [SUM_W-1:0]     acc_q, sum_s4;
	logic                 first_s4, final_s4;

	assign prod     = $signed(d_s2) * $signed(d_s2);
	assign first_s4 = (row_s4 == '0) && (col_s4 == '0);
	assign final_s4 = sv_s4 && (row_s4 == RC_W'(GRID_SIDE - 1))
		&& (col_s4 == RC_W'(GRID_SIDE - 1));

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			sv_s4 <= 1'b0;
		end else begin
			v_s1  <= (state_q == ST_WALK);
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			sv_s4 <= v_s3 && lk_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		q_s1   <= qbuf_q[k_q];
		lk_s1  <= k_last;
		row_s1 <= row_q;
		col_s1 <= col_q;

		d_s2   <= {rd_s1[VB-1], rd_s1} - {q_s1[VB-1], q_s1};
		lk_s2  <= lk_s1;
		row_s2 <= row_s1;
		col_s2 <= col_s1;

		sq_s3  <= SQ_W'(prod);
		lk_s3  <= lk_s2;
		row_s3 <= row_s2;
		col_s3 <= col_s2;

		// accumulate one entry; hand over the sum on its final element
		if (v_s3) begin
			if (lk_s3) begin
				sum_s4 <= acc_q + SUM_W'(sq_s3);
				acc_q  <= '0;
				row_s4 <= row_s3;
				col_s4 <= col_s3;
			end else begin
				acc_q <= acc_q + SUM_W'(sq_s3);
			end
		end
		if (start) begin
			acc_q <= '0;
		end
	end

	// running minimum; strict compare keeps the first entry on a tie
	logic [SUM_W-1:0] best_d_q;
	logic [RC_W-1:0]  best_row_q, best_col_q;

	always_ff @(posedge clk) begin
		if (sv_s4 && (first_s4 || (sum_s4 < best_d_q))) begin
			best_d_q   <= sum_s4;
			best_row_q <= row_s4;
			best_col_q <= col_s4;
		end
	end

	// walk address generation
	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= '0;
			k_q    <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (state_q == ST_WALK) begin
			addr_q <= addr_q + ADDR_W'(1);
			if (k_last) begin
				k_q <= '0;
				if (col_last) begin
					col_q <= '0;
					row_q <= row_q + RC_W'(1);
				end else begin
					col_q <= col_q + RC_W'(1);
				end
			end else begin
				k_q <= k_q + K_W'(1);
			end
		end
	end

	// result formatting with saturation
	logic [CMP_W-1:0]              best_ext;
	logic [som_bmu_pkg::DIST_W-1:0] dist_sat;
	logic                          rsp_free, load_rsp;

	assign best_ext = CMP_W'(best_d_q);
	assign dist_sat = (best_ext > CMP_W'(som_bmu_pkg::DIST_MAX))
		? som_bmu_pkg::DIST_MAX : som_bmu_pkg::DIST_W'(best_ext);
	assign rsp_free = !rsp_valid || !rsp_stall;
	assign load_rsp = (state_q == ST_DONE) && rsp_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (addr_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (final_s4) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp.best_row     <= 4'(best_row_q);
			rsp.best_col     <= 4'(best_col_q);
			rsp.min_distance <= dist_sat;
		end
	end

	// entry sums only appear while a walk is running or draining
	a_sum_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		sv_s4 |-> (state_q == ST_WALK || state_q == ST_DRAIN))
		else $error("entry sum outside a walk");

	// the last entry's sum ends the walk
	a_final_done: assert property (@(posedge clk) disable iff (!arst_n)
		final_s4 |=> (state_q == ST_DONE))
		else $error("walk did not finish after last entry");

	// a new result comes only from the done state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside done state");

	// no codebook or query buffer write while a search is busy
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cb_we && !qb_we)
		else $error("store written during search");

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int NUM_ENTRIES   = som_bmu_pkg::GRID_SIDE_DEF * som_bmu_pkg::GRID_SIDE_DEF;
	localparam int PATCH_LEN     = som_bmu_pkg::PATCH_SIDE_DEF * som_bmu_pkg::PATCH_SIDE_DEF;
	localparam int CB_WORDS      = NUM_ENTRIES * PATCH_LEN;
	// one full codebook walk plus pipeline slack
	localparam int SEARCH_CYCLES = NUM_ENTRIES * PATCH_LEN + 6;
	localparam int STALL_MAX     = 9;
	localparam int WATCHDOG_MAX  = 4 * (SEARCH_CYCLES + 2 * (STALL_MAX + 1));
	localparam int RANDOM_ITEMS  = 1450;

	// one row of the directed plan
	typedef struct packed {
		som_bmu_pkg::req_t it;
		bit                typed;
		som_bmu_pkg::rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	som_bmu_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	som_bmu_pkg::rsp_t rsp;

	// local copy of the codebook and the query patch
	logic signed [15:0] cb_words [CB_WORDS];
	logic signed [15:0] query_words [PATCH_LEN];

	som_bmu_pkg::rsp_t pending_matches [$];
	int   mismatches = 0;
	int   items_sent = 0;
	int   matches_seen = 0;

	som_best_matching_unit_search_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic som_bmu_pkg::req_t make_req(logic f, int entry, int elem,
		logic [15:0] v, logic l);
		som_bmu_pkg::req_t r;
		r.func    = f;
		r.entry   = entry[7:0];
		r.element = elem[3:0];
		r.value   = v;
		r.last    = l;
		return r;
	endfunction

	// mostly small values so that ties and near misses happen
	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
			default: return 16'(int'($urandom_range(0, 8)) - 4);
		endcase
	endfunction

	// exhaustive nearest-entry search over the local codebook
	function automatic som_bmu_pkg::rsp_t closest_entry();
		som_bmu_pkg::rsp_t r;
		longint unsigned best_d;
		longint unsigned d;
		longint diff;
		int best_e;
		int e;
		int k;
		best_e = 0;
		best_d = 0;
		for (e = 0; e < NUM_ENTRIES; e++) begin
			d = 0;
			for (k = 0; k < PATCH_LEN; k++) begin
				diff = longint'(cb_words[e * PATCH_LEN + k]) - longint'(query_words[k]);
				d += longint'(diff * diff);
			end
			// strict less-than keeps the first entry on a tie
			if (e == 0 || d < best_d) begin
				best_d = d;
				best_e = e;
			end
		end
		if (best_d > som_bmu_pkg::DIST_MAX)
			best_d = som_bmu_pkg::DIST_MAX;
		r.best_row     = 4'(best_e / som_bmu_pkg::GRID_SIDE_DEF);
		r.best_col     = 4'(best_e % som_bmu_pkg::GRID_SIDE_DEF);
		r.min_distance = best_d[som_bmu_pkg::DIST_W-1:0];
		return r;
	endfunction

	// apply one item to the local state; returns 1 when it triggers a search
	function automatic bit take_item(som_bmu_pkg::req_t it, output som_bmu_pkg::rsp_t r);
		int idx;
		r = '0;
		if (it.func == som_bmu_pkg::FUNC_WRITE) begin
			idx = int'(it.entry) * PATCH_LEN + int'(it.element);
			if (int'(it.entry) < NUM_ENTRIES && int'(it.element) < PATCH_LEN)
				cb_words[idx] = it.value;
			return 1'b0;
		end
		if (int'(it.element) < PATCH_LEN)
			query_words[it.element] = it.value;
		if (!it.last)
			return 1'b0;
		r = closest_entry();
		return 1'b1;
	endfunction

	// drive one item after a random gap and wait for it to be taken
	task automatic push_item(som_bmu_pkg::req_t it, bit typed, som_bmu_pkg::rsp_t want);
		int gap;
		som_bmu_pkg::rsp_t got;
		gap = $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (req_stall !== 1'b0);
		if (take_item(it, got))
			pending_matches.push_back(typed ? want : got);
		items_sent++;
	endtask

	// result side: stall for a drawn number of cycles while a result waits
	initial begin
		int hold;
		som_bmu_pkg::rsp_t want;
		hold = $urandom_range(0, STALL_MAX);
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				matches_seen++;
				if (pending_matches.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result row %0d col %0d dist %0d", $time,
						rsp.best_row, rsp.best_col, rsp.min_distance);
				end else begin
					want = pending_matches.pop_front();
					if (rsp.best_row !== want.best_row) begin
						mismatches++;
						$display("%0t: best_row expected %0d got %0d", $time,
							want.best_row, rsp.best_row);
					end
					if (rsp.best_col !== want.best_col) begin
						mismatches++;
						$display("%0t: best_col expected %0d got %0d", $time,
							want.best_col, rsp.best_col);
					end
					if (rsp.min_distance !== want.min_distance) begin
						mismatches++;
						$display("%0t: min_distance expected %0d got %0d", $time,
							want.min_distance, rsp.min_distance);
					end
				end
				hold = $urandom_range(0, STALL_MAX);
			end else if (rsp_valid === 1'b1 && hold > 0) begin
				hold--;
			end
			rsp_stall <= (hold > 0);
		end
	end

	// watchdog: too long without any item moving on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_MAX) begin
			@(posedge clk);
			if ((req_valid === 1'b1 && req_stall === 1'b0) ||
			    (rsp_valid === 1'b1 && rsp_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no progress for %0d cycles", $time, WATCHDOG_MAX);
		$display("tb: errors");
		$finish;
	end

	// stimulus
	initial begin
		plan_row_t plan [21];
		int order [PATCH_LEN];
		int i;
		int j;
		int t;
		int n;
		int pick;
		int src;
		int noise;
		int base;
		logic [15:0] v;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// clear the whole codebook so every entry is defined
		for (i = 0; i < CB_WORDS; i++)
			push_item(make_req(som_bmu_pkg::FUNC_WRITE, i / PATCH_LEN, i % PATCH_LEN,
				16'h0000, 1'b0), 1'b0, '0);

		// directed: all-zero tie, extremes, out-of-range elements, stale query words
		plan = '{
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 0, 16'h0000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 1, 16'h0000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 2, 16'h0000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 3, 16'h0000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 4, 16'h0000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 5, 16'h0000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 6, 16'h0000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 7, 16'h0000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 8, 16'h0000, 1'b1), 1'b1,
				'{4'd0, 4'd0, 36'd0}},
			'{make_req(som_bmu_pkg::FUNC_WRITE, 255, 4, 16'd100, 1'b1), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 4, 16'd100, 1'b1), 1'b1,
				'{4'd15, 4'd15, 36'd0}},
			'{make_req(som_bmu_pkg::FUNC_WRITE, 17, 0, 16'h8000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_WRITE, 200, 0, 16'h8000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 0, 16'h8000, 1'b1), 1'b1,
				'{4'd1, 4'd1, 36'd10000}},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 4, 16'h0000, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 9, 16'd1234, 1'b1), 1'b1,
				'{4'd1, 4'd1, 36'd0}},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 15, 16'h7fff, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_WRITE, 5, 12, 16'd7, 1'b0), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 0, 0, 16'h7fff, 1'b1), 1'b1,
				'{4'd0, 4'd0, 36'd1073676289}},
			'{make_req(som_bmu_pkg::FUNC_WRITE, 0, 8, 16'h7fff, 1'b1), 1'b0, '0},
			'{make_req(som_bmu_pkg::FUNC_QUERY, 255, 8, 16'h8000, 1'b1), 1'b0, '0}
		};
		for (i = 0; i < 21; i++)
			push_item(plan[i].it, plan[i].typed, plan[i].want);

		// random refill of the codebook
		for (i = 0; i < CB_WORDS; i++)
			push_item(make_req(som_bmu_pkg::FUNC_WRITE, i / PATCH_LEN, i % PATCH_LEN,
				rand_value(), 1'($urandom)), 1'b0, '0);

		// random mix: full queries, write bursts, short stale queries, noise
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				for (i = 0; i < PATCH_LEN; i++)
					order[i] = i;
				for (i = PATCH_LEN - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = order[i];
					order[i] = order[j];
					order[j] = t;
				end
				src = $urandom_range(0, NUM_ENTRIES - 1);
				n = $urandom_range(0, 2);
				for (i = 0; i < PATCH_LEN; i++) begin
					// mostly a near copy of one entry, else fresh values
					if (n != 0) begin
						noise = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4)) - 2 : 0;
						v = 16'(int'(cb_words[src * PATCH_LEN + order[i]]) + noise);
					end else begin
						v = rand_value();
					end
					push_item(make_req(som_bmu_pkg::FUNC_QUERY, $urandom_range(0, 255),
						order[i], v, i == PATCH_LEN - 1), 1'b0, '0);
				end
			end else if (pick < 75) begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++)
					push_item(make_req(som_bmu_pkg::FUNC_WRITE, $urandom_range(0, 255),
						($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
							: $urandom_range(0, PATCH_LEN - 1),
						rand_value(), 1'($urandom)), 1'b0, '0);
			end else if (pick < 90) begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					push_item(make_req(som_bmu_pkg::FUNC_QUERY, $urandom_range(0, 255),
						$urandom_range(0, PATCH_LEN - 1), rand_value(), i == n - 1),
						1'b0, '0);
			end else begin
				push_item(make_req(1'($urandom), $urandom_range(0, 255), $urandom_range(0, 15),
					16'($urandom), 1'($urandom)), 1'b0, '0);
			end
		end
		req_valid <= 1'b0;

		// drain, then watch for stray results
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (SEARCH_CYCLES + 2 * (STALL_MAX + 1)) @(posedge clk);

		$display("summary: %0d items sent, %0d search results checked", items_sent,
			matches_seen);
		$display("summary: zero-codebook directed cases, random refill, mixed queries/writes");
		if (mismatches == 0 && pending_matches.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/som_bmu_pkg.sv
hw/rtl/som_best_matching_unit_search_top.sv
test/tb.sv
